@@ sv/lpcr_pkg.sv @@
// Shared constants, register indexes and types of the LED panel coordinate remapper.
package lpcr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS_DEF = 8;
  localparam int FOLD_SPAN_DEF  = 64;

  localparam int POS_BITS   = 13;
  localparam int OUT_BITS   = 11;
  localparam int OUT_LIMIT  = 2048;
  localparam int CHAIN_BITS = 4;
  localparam int ROT_BITS   = 2;
  localparam int QUO_BITS   = 5;
  localparam int QUO_SPLIT  = 2;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int IDX_BITS  = 3;

  localparam logic [IDX_BITS-1:0] REG_PHYS_WIDTH  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_PHYS_HEIGHT = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_CHAINS      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ROTATION    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_FOLD_ENABLE = 3'd4;

  localparam logic [ROT_BITS-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_BITS-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_BITS-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_BITS-1:0] ROT_270 = 2'd3;

  localparam int PHYS_WIDTH_RESET  = 64;
  localparam int PHYS_HEIGHT_RESET = 32;
  localparam int CHAINS_RESET      = 1;

  typedef struct packed {
    logic busy;
    logic done;
  } lpcr_div_sts_t;

endpackage

@@ sv/lpcr_div.sv @@
// Restoring divider that produces one quotient bit per cycle for the derived geometry.
module lpcr_div
  import lpcr_pkg::*;
#(
  parameter int NW = 12,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quotient_o,
  output lpcr_div_sts_t sts_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   div_q, div_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     shifted;
  logic [DW:0]     diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign quotient_o = quo_q;
  assign sts_o      = '{busy: busy_q, done: done_q};

endmodule

@@ sv/led_panel_coordinate_remapper_unit.sv @@
// Top level of the LED panel coordinate remapper: register port, derived geometry and pipeline.
// The remapper takes one pixel item per cycle, unless a stalled output or a pending geometry
// recompute holds off the input, through five register stages (rotation, fold bound check with
// the upper quotient bits of the slab division, the lower quotient bits, slab base multiply with
// the fold, then the physical bound check in the output register); a stalled output holds the
// pipeline without losing items. The U canvas width follows the width register in the cycle
// after a write through a reciprocal multiplication, and the panel height is recomputed by a
// one-bit-per-cycle divider: after any register write the input is held off until the new
// panel height is stored.
module led_panel_coordinate_remapper_unit
  import lpcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  parameter int FOLD_SPAN  = FOLD_SPAN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_BITS-1:0]       paddr,
  input  logic [DATA_BITS-1:0]       pwdata,
  output logic [DATA_BITS-1:0]       prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [POS_BITS-1:0] pos_x_i,
  input  logic signed [POS_BITS-1:0] pos_y_i,
  input  logic [COLOR_BITS-1:0]      red_in_i,
  input  logic [COLOR_BITS-1:0]      green_in_i,
  input  logic [COLOR_BITS-1:0]      blue_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OUT_BITS-1:0]        panel_x_o,
  output logic [OUT_BITS-1:0]        panel_y_o,
  output logic [COLOR_BITS-1:0]      red_out_o,
  output logic [COLOR_BITS-1:0]      green_out_o,
  output logic [COLOR_BITS-1:0]      blue_out_o,
  output logic                       visible_o
);

  localparam int SW        = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 3;
  localparam int UB        = SW - 1;
  localparam int RW        = COORD_BITS + 1;
  localparam int QW        = RW + QUO_BITS;
  localparam int BW        = COORD_BITS + QUO_BITS;
  localparam int FW        = BW + 1;
  localparam int CW        = 3 * COLOR_BITS;
  localparam int HALF_SPAN = FOLD_SPAN / 2;
  localparam int UW_RESET  = (PHYS_WIDTH_RESET / FOLD_SPAN) * HALF_SPAN;
  localparam int PH_RESET  = PHYS_HEIGHT_RESET / CHAINS_RESET;

  // The reciprocal of the fold span is exact for every width value of COORD_BITS bits.
  localparam int     SPAN_LOG = $clog2(FOLD_SPAN);
  localparam int     REC_SH   = COORD_BITS + SPAN_LOG;
  localparam int     REC_W    = COORD_BITS + 2;
  localparam int     PROD_W   = COORD_BITS + REC_W;
  localparam longint REC_M    = ((longint'(1) << REC_SH) + longint'(FOLD_SPAN) - 1) /
                                longint'(FOLD_SPAN);

  localparam logic [1:0] CS_IDLE   = 2'd0;
  localparam logic [1:0] CS_HEIGHT = 2'd1;

  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  // Configuration registers and read port.
  logic [COORD_BITS-1:0] pw_q, ph_q;
  logic [CHAIN_BITS-1:0] chains_q;
  logic [ROT_BITS-1:0]   rot_q;
  logic                  fold_q;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q     <= COORD_BITS'(PHYS_WIDTH_RESET);
      ph_q     <= COORD_BITS'(PHYS_HEIGHT_RESET);
      chains_q <= CHAIN_BITS'(CHAINS_RESET);
      rot_q    <= ROT_0;
      fold_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PHYS_WIDTH:  pw_q     <= pwdata[COORD_BITS-1:0];
        REG_PHYS_HEIGHT: ph_q     <= pwdata[COORD_BITS-1:0];
        REG_CHAINS:      chains_q <= pwdata[CHAIN_BITS-1:0];
        REG_ROTATION:    rot_q    <= pwdata[ROT_BITS-1:0];
        REG_FOLD_ENABLE: fold_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PHYS_WIDTH:  prdata = DATA_BITS'(pw_q);
      REG_PHYS_HEIGHT: prdata = DATA_BITS'(ph_q);
      REG_CHAINS:      prdata = DATA_BITS'(chains_q);
      REG_ROTATION:    prdata = DATA_BITS'(rot_q);
      REG_FOLD_ENABLE: prdata = DATA_BITS'(fold_q);
      default:         prdata = '0;
    endcase
  end

  // Derived geometry: U canvas width and panel height.
  logic [1:0]            cs_q, cs_d;
  logic                  pend_q, pend_d;
  logic [COORD_BITS-1:0] uw_q, uw_d;
  logic [COORD_BITS-1:0] panel_h_q, panel_h_d;
  logic [PROD_W-1:0]     span_prod;
  logic [COORD_BITS-1:0] span_quo;
  logic                  div_start;
  logic [COORD_BITS-1:0] div_dividend;
  logic [CHAIN_BITS-1:0] div_divisor;
  logic [COORD_BITS-1:0] div_quo;
  lpcr_div_sts_t         div_sts;
  logic [CHAIN_BITS-1:0] chains_eff;
  logic                  cfg_busy;

  assign span_prod    = PROD_W'(pw_q) * PROD_W'(REC_M);
  assign span_quo     = COORD_BITS'(span_prod >> REC_SH);
  assign uw_d         = COORD_BITS'(span_quo * COORD_BITS'(HALF_SPAN));
  assign chains_eff   = (chains_q == '0) ? CHAIN_BITS'(1) : chains_q;
  assign div_start    = (cs_q == CS_IDLE) && pend_q;
  assign div_dividend = ph_q;
  assign div_divisor  = chains_eff;
  assign cfg_busy     = pend_q || (cs_q != CS_IDLE);

  lpcr_div #(
    .NW(COORD_BITS),
    .DW(CHAIN_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .sts_o      (div_sts)
  );

  always_comb begin
    cs_d      = cs_q;
    panel_h_d = panel_h_q;
    pend_d    = wr_en ? 1'b1 : ((cs_q == CS_IDLE) ? 1'b0 : pend_q);
    unique case (cs_q)
      CS_IDLE: begin
        if (pend_q) begin
          cs_d = CS_HEIGHT;
        end
      end
      CS_HEIGHT: begin
        if (div_sts.done) begin
          panel_h_d = div_quo;
          cs_d      = CS_IDLE;
        end
      end
      default: cs_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q      <= CS_IDLE;
      pend_q    <= 1'b0;
      uw_q      <= COORD_BITS'(UW_RESET);
      panel_h_q <= COORD_BITS'(PH_RESET);
    end else begin
      cs_q      <= cs_d;
      pend_q    <= pend_d;
      uw_q      <= uw_d;
      panel_h_q <= panel_h_d;
    end
  end

  // Pipeline flow control.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic en1, en2, en3, en4, en_out;

  assign en_out     = !out_v_q || out_ready_i;
  assign en4        = !s4_v_q || en_out;
  assign en3        = !s3_v_q || en4;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_ready_o = en1 && !cfg_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= in_valid_i && in_ready_o;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en4) begin
        s4_v_q <= s3_v_q;
      end
      if (en_out) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // Stage 1: rotation on the active canvas.
  logic [RW-1:0]          cw_u, chh_u;
  logic signed [SW-1:0]   cw_s, chh_s, x_s, y_s, rx1, ry1;
  logic signed [SW-1:0]   s1_rx_q, s1_ry_q;
  logic [CW-1:0]          s1_col_q;

  assign cw_u  = fold_q ? {1'b0, uw_q} : {1'b0, pw_q};
  assign chh_u = fold_q ? {ph_q, 1'b0} : {1'b0, ph_q};
  assign cw_s  = signed'(SW'(cw_u));
  assign chh_s = signed'(SW'(chh_u));
  assign x_s   = SW'(pos_x_i);
  assign y_s   = SW'(pos_y_i);

  always_comb begin
    unique case (rot_q)
      ROT_90: begin
        rx1 = cw_s - y_s - ONE_S;
        ry1 = x_s;
      end
      ROT_180: begin
        rx1 = cw_s - x_s - ONE_S;
        ry1 = chh_s - y_s - ONE_S;
      end
      ROT_270: begin
        rx1 = y_s;
        ry1 = chh_s - x_s - ONE_S;
      end
      default: begin
        rx1 = x_s;
        ry1 = y_s;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_rx_q  <= rx1;
      s1_ry_q  <= ry1;
      s1_col_q <= {red_in_i, green_in_i, blue_in_i};
    end
  end

  // Stage 2: U canvas bound check and the upper quotient bits of row / slab.
  logic                 in_u;
  logic [QW-1:0]        slab_w;
  logic [QW-1:0]        rem2;
  logic [QUO_BITS-1:0]  quo2;
  logic signed [SW-1:0] s2_rx_q, s2_ry_q;
  logic [RW-1:0]        s2_rem_q;
  logic [QUO_BITS-1:0]  s2_quo_q;
  logic                 s2_uf_q, s2_drop_q;
  logic [CW-1:0]        s2_col_q;

  assign slab_w = QW'({panel_h_q, 1'b0});
  assign in_u   = !s1_rx_q[SW-1] && !s1_ry_q[SW-1] &&
                  (s1_rx_q[UB-1:0] < UB'(uw_q)) &&
                  (s1_ry_q[UB-1:0] < UB'({ph_q, 1'b0})) &&
                  (panel_h_q != '0);

  always_comb begin
    rem2 = QW'(s1_ry_q[RW-1:0]);
    quo2 = '0;
    for (int k = QUO_BITS - 1; k >= QUO_SPLIT; k--) begin
      if (rem2 >= (slab_w << k)) begin
        rem2    = rem2 - (slab_w << k);
        quo2[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_rx_q   <= s1_rx_q;
      s2_ry_q   <= s1_ry_q;
      s2_rem_q  <= rem2[RW-1:0];
      s2_quo_q  <= quo2;
      s2_uf_q   <= fold_q && in_u;
      s2_drop_q <= fold_q && !in_u;
      s2_col_q  <= s1_col_q;
    end
  end

  // Stage 3: lower quotient bits and the row within the slab.
  logic [QW-1:0]        rem3;
  logic [QUO_BITS-1:0]  quo3;
  logic signed [SW-1:0] s3_rx_q, s3_ry_q;
  logic [RW-1:0]        s3_rem_q;
  logic [QUO_BITS-1:0]  s3_quo_q;
  logic                 s3_uf_q, s3_drop_q;
  logic [CW-1:0]        s3_col_q;

  always_comb begin
    rem3 = QW'(s2_rem_q);
    quo3 = s2_quo_q;
    for (int k = QUO_SPLIT - 1; k >= 0; k--) begin
      if (rem3 >= (slab_w << k)) begin
        rem3    = rem3 - (slab_w << k);
        quo3[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_rx_q   <= s2_rx_q;
      s3_ry_q   <= s2_ry_q;
      s3_rem_q  <= rem3[RW-1:0];
      s3_quo_q  <= quo3;
      s3_uf_q   <= s2_uf_q;
      s3_drop_q <= s2_drop_q;
      s3_col_q  <= s2_col_q;
    end
  end

  // Stage 4: slab base row and the fold of each slab half.
  logic                 lower;
  logic [RW-1:0]        slab_r;
  logic [RW-1:0]        yy4;
  logic signed [SW-1:0] rx4;
  logic signed [SW-1:0] half_pw_s, uw_s;
  logic [BW-1:0]        base4;
  logic signed [SW-1:0] s4_rx_q, s4_ry_q;
  logic [BW-1:0]        s4_base_q;
  logic [RW-1:0]        s4_yy_q;
  logic                 s4_uf_q, s4_drop_q;
  logic [CW-1:0]        s4_col_q;

  assign slab_r    = {panel_h_q, 1'b0};
  assign lower     = s3_rem_q < {1'b0, panel_h_q};
  assign half_pw_s = signed'(SW'(pw_q >> 1));
  assign uw_s      = signed'(SW'(uw_q));
  assign base4     = BW'(s3_quo_q) * BW'(panel_h_q);
  assign yy4       = lower ? s3_rem_q : (slab_r - s3_rem_q - RW'(1));

  always_comb begin
    if (!s3_uf_q) begin
      rx4 = s3_rx_q;
    end else if (lower) begin
      rx4 = s3_rx_q + half_pw_s;
    end else begin
      rx4 = uw_s - s3_rx_q - ONE_S;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_rx_q   <= rx4;
      s4_ry_q   <= s3_ry_q;
      s4_base_q <= base4;
      s4_yy_q   <= yy4;
      s4_uf_q   <= s3_uf_q;
      s4_drop_q <= s3_drop_q;
      s4_col_q  <= s3_col_q;
    end
  end

  // Stage 5: final row, physical bound check and output register.
  logic [FW-1:0]       ry_f;
  logic                rx_ok, ry_ok, vis;
  logic [OUT_BITS-1:0] ry_val;
  logic [OUT_BITS-1:0] px_q, py_q;
  logic                vis_q;
  logic [CW-1:0]       col_q;

  assign ry_f  = FW'(s4_base_q) + FW'(s4_yy_q);
  assign rx_ok = !s4_rx_q[SW-1] && (s4_rx_q[UB-1:0] < UB'(pw_q)) &&
                 (s4_rx_q[UB-1:0] < UB'(OUT_LIMIT));

  always_comb begin
    if (s4_uf_q) begin
      ry_ok  = (ry_f < FW'(ph_q)) && (ry_f < FW'(OUT_LIMIT));
      ry_val = ry_f[OUT_BITS-1:0];
    end else begin
      ry_ok  = !s4_ry_q[SW-1] && (s4_ry_q[UB-1:0] < UB'(ph_q)) &&
               (s4_ry_q[UB-1:0] < UB'(OUT_LIMIT));
      ry_val = s4_ry_q[OUT_BITS-1:0];
    end
  end

  assign vis = !s4_drop_q && rx_ok && ry_ok;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      px_q  <= vis ? s4_rx_q[OUT_BITS-1:0] : '0;
      py_q  <= vis ? ry_val : '0;
      vis_q <= vis;
      col_q <= s4_col_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign panel_x_o   = px_q;
  assign panel_y_o   = py_q;
  assign visible_o   = vis_q;
  assign red_out_o   = col_q[CW-1:2*COLOR_BITS];
  assign green_out_o = col_q[2*COLOR_BITS-1:COLOR_BITS];
  assign blue_out_o  = col_q[COLOR_BITS-1:0];

endmodule

@@ sv/lpcr_checker.sv @@
// Port-level checks of the LED panel coordinate remapper and their bind to the top level.
module lpcr_checker
  import lpcr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic                pready,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [OUT_BITS-1:0] panel_x_o,
  input logic [OUT_BITS-1:0] panel_y_o,
  input logic                visible_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(visible_o) && $stable(panel_x_o))
    else $error("A stalled result item changed or was dropped.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("The register port inserted a wait state.");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> (panel_x_o == '0) && (panel_y_o == '0))
    else $error("An invisible item carries a nonzero coordinate.");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !in_ready_o)
    else $error("An item could be taken before the geometry was recomputed.");

endmodule

bind led_panel_coordinate_remapper_unit lpcr_checker u_lpcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .panel_x_o   (panel_x_o),
  .panel_y_o   (panel_y_o),
  .visible_o   (visible_o)
);

@@ dv/led_panel_coordinate_remapper_unit_tb.sv @@
// Self-checking testbench for the LED panel coordinate remapper unit.
module led_panel_coordinate_remapper_unit_tb;
  import lpcr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 119;

  typedef struct {
    logic [POS_BITS-1:0]       pos_x;
    logic [POS_BITS-1:0]       pos_y;
    logic [COLOR_BITS_DEF-1:0] red;
    logic [COLOR_BITS_DEF-1:0] green;
    logic [COLOR_BITS_DEF-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]       panel_x;
    logic [OUT_BITS-1:0]       panel_y;
    logic [COLOR_BITS_DEF-1:0] red;
    logic [COLOR_BITS_DEF-1:0] green;
    logic [COLOR_BITS_DEF-1:0] blue;
    logic                      visible;
  } remap_t;

  typedef struct {
    logic [COORD_BITS_DEF-1:0] width;
    logic [COORD_BITS_DEF-1:0] height;
    logic [CHAIN_BITS-1:0]     chains;
    logic [ROT_BITS-1:0]       rotation;
    logic                      fold;
  } geometry_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_BITS-1:0]      paddr = '0;
  logic [DATA_BITS-1:0]      pwdata = '0;
  logic [DATA_BITS-1:0]      prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [POS_BITS-1:0]       pos_x_i = '0;
  logic [POS_BITS-1:0]       pos_y_i = '0;
  logic [COLOR_BITS_DEF-1:0] red_in_i = '0;
  logic [COLOR_BITS_DEF-1:0] green_in_i = '0;
  logic [COLOR_BITS_DEF-1:0] blue_in_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [OUT_BITS-1:0]       panel_x_o;
  logic [OUT_BITS-1:0]       panel_y_o;
  logic [COLOR_BITS_DEF-1:0] red_out_o;
  logic [COLOR_BITS_DEF-1:0] green_out_o;
  logic [COLOR_BITS_DEF-1:0] blue_out_o;
  logic                      visible_o;

  geometry_t geom = '{12'(PHYS_WIDTH_RESET), 12'(PHYS_HEIGHT_RESET), 4'(CHAINS_RESET),
                      ROT_0, 1'b0};
  remap_t pending_remaps[$];
  int send_idle_pct = 37;
  int recv_idle_pct = 60;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  led_panel_coordinate_remapper_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .red_in_i(red_in_i),
    .green_in_i(green_in_i),
    .blue_in_i(blue_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .panel_x_o(panel_x_o),
    .panel_y_o(panel_y_o),
    .red_out_o(red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o(blue_out_o),
    .visible_o(visible_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void canvas_size(output int cw, output int chh);
    if (geom.fold) begin
      cw = (int'(geom.width) / FOLD_SPAN_DEF) * (FOLD_SPAN_DEF / 2);
      chh = 2 * int'(geom.height);
    end else begin
      cw = int'(geom.width);
      chh = int'(geom.height);
    end
  endfunction

  function automatic remap_t remap_pixel(pixel_t p);
    int x, y, pw, ph, uw, cw, chh, rx, ry, chains, panel_h, slab, yy;
    bit vis;
    remap_t r;
    x = int'($signed(p.pos_x));
    y = int'($signed(p.pos_y));
    pw = int'(geom.width);
    ph = int'(geom.height);
    uw = (pw / FOLD_SPAN_DEF) * (FOLD_SPAN_DEF / 2);
    canvas_size(cw, chh);
    vis = 1'b1;
    case (geom.rotation)
      ROT_90: begin
        rx = cw - y - 1;
        ry = x;
      end
      ROT_180: begin
        rx = cw - x - 1;
        ry = chh - y - 1;
      end
      ROT_270: begin
        rx = y;
        ry = chh - x - 1;
      end
      default: begin
        rx = x;
        ry = y;
      end
    endcase
    if (geom.fold) begin
      chains = (geom.chains == 0) ? 1 : int'(geom.chains);
      panel_h = ph / chains;
      if (rx < 0 || rx >= uw || ry < 0 || ry >= 2 * ph || panel_h == 0) begin
        vis = 1'b0;
      end else begin
        slab = 2 * panel_h;
        yy = ry % slab;
        if (yy < panel_h) begin
          rx = rx + pw / 2;
        end else begin
          rx = uw - rx - 1;
          yy = slab - yy - 1;
        end
        ry = (ry / slab) * panel_h + yy;
      end
    end
    if (rx < 0 || rx >= pw || ry < 0 || ry >= ph || rx >= OUT_LIMIT || ry >= OUT_LIMIT) begin
      vis = 1'b0;
    end
    r.panel_x = vis ? rx[OUT_BITS-1:0] : '0;
    r.panel_y = vis ? ry[OUT_BITS-1:0] : '0;
    r.red = p.red;
    r.green = p.green;
    r.blue = p.blue;
    r.visible = vis;
    return r;
  endfunction

  // A negative shade gives random colors.
  function automatic pixel_t pixel_at(int x, int y, int shade);
    pixel_t p;
    p.pos_x = x[POS_BITS-1:0];
    p.pos_y = y[POS_BITS-1:0];
    if (shade < 0) begin
      p.red = COLOR_BITS_DEF'($urandom);
      p.green = COLOR_BITS_DEF'($urandom);
      p.blue = COLOR_BITS_DEF'($urandom);
    end else begin
      p.red = shade[COLOR_BITS_DEF-1:0];
      p.green = shade[COLOR_BITS_DEF-1:0];
      p.blue = shade[COLOR_BITS_DEF-1:0];
    end
    return p;
  endfunction

  // Most pixels land on or just around the logical canvas of the current geometry.
  function automatic pixel_t random_pixel();
    int cw, chh, span_x, span_y, x, y;
    canvas_size(cw, chh);
    if (geom.rotation[0]) begin
      span_x = chh;
      span_y = cw;
    end else begin
      span_x = cw;
      span_y = chh;
    end
    if ($urandom_range(7) == 0) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = int'($urandom_range(0, span_x + 7)) - 4;
      y = int'($urandom_range(0, span_y + 7)) - 4;
    end
    return pixel_at(x, y, -1);
  endfunction

  task automatic send_pixel(pixel_t p);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= p.pos_x;
    pos_y_i <= p.pos_y;
    red_in_i <= p.red;
    green_in_i <= p.green;
    blue_in_i <= p.blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_remaps = {pending_remaps, remap_pixel(p)};
  endtask

  task automatic drain_stream();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_remaps.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic apply_geometry(geometry_t g);
    drain_stream();
    write_reg(REG_PHYS_WIDTH, DATA_BITS'(g.width));
    write_reg(REG_PHYS_HEIGHT, DATA_BITS'(g.height));
    write_reg(REG_CHAINS, DATA_BITS'(g.chains));
    write_reg(REG_ROTATION, DATA_BITS'(g.rotation));
    write_reg(REG_FOLD_ENABLE, DATA_BITS'(g.fold));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    geom = g;
  endtask

  task automatic test_reset_defaults();
    send_pixel(pixel_at(0, 0, 0));
    send_pixel(pixel_at(63, 31, 255));
    send_pixel(pixel_at(64, 0, -1));
    send_pixel(pixel_at(0, 32, -1));
    send_pixel(pixel_at(-1, -1, -1));
    send_pixel(pixel_at(-4096, -4096, 255));
    send_pixel(pixel_at(4095, 4095, 0));
  endtask

  task automatic test_rotations();
    logic [ROT_BITS-1:0] turns[3] = '{ROT_90, ROT_180, ROT_270};
    foreach (turns[i]) begin
      apply_geometry('{12'd64, 12'd32, 4'd1, turns[i], 1'b0});
      send_pixel(pixel_at(0, 0, -1));
      send_pixel(pixel_at(31, 63, -1));
    end
  endtask

  task automatic test_fold();
    apply_geometry('{12'd128, 12'd32, 4'd2, ROT_0, 1'b1});
    send_pixel(pixel_at(5, 3, -1));
    send_pixel(pixel_at(5, 20, -1));
    send_pixel(pixel_at(10, 40, -1));
    send_pixel(pixel_at(64, 0, -1));
  endtask

  task automatic test_fold_corner_cases();
    // Zero chains behaves as one chain.
    apply_geometry('{12'd128, 12'd32, 4'd0, ROT_0, 1'b1});
    send_pixel(pixel_at(3, 3, -1));
    // More chains than rows leaves no panel height at all.
    apply_geometry('{12'd128, 12'd4, 4'd8, ROT_90, 1'b1});
    send_pixel(pixel_at(0, 0, -1));
    // Chains that do not divide the height drop the rows past the bottom.
    apply_geometry('{12'd128, 12'd30, 4'd4, ROT_0, 1'b1});
    send_pixel(pixel_at(0, 58, -1));
    send_pixel(pixel_at(0, 3, -1));
    // Physical columns past the output range are dropped.
    apply_geometry('{12'hFFF, 12'd2048, 4'd1, ROT_0, 1'b1});
    send_pixel(pixel_at(2015, 0, -1));
    send_pixel(pixel_at(0, 0, -1));
    apply_geometry('{12'hFFF, 12'hFFF, 4'd1, ROT_0, 1'b0});
    send_pixel(pixel_at(3000, 5, -1));
  endtask

  task automatic test_random_traffic();
    geometry_t g;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < RANDOM_PHASES / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 60;
      end else if (phase < 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: g = '{12'd2048, 12'd2048, 4'd8, ROT_270, 1'b1};
        1: g = '{12'd1, 12'd1, 4'd1, ROT_90, 1'b0};
        2: g = '{12'hFFF, 12'hFFF, 4'hF, ROT_180, 1'b1};
        default: begin
          g.fold = 1'($urandom_range(1));
          if (g.fold && $urandom_range(3) != 0) begin
            g.width = COORD_BITS_DEF'(64 * $urandom_range(1, 32));
          end else begin
            g.width = COORD_BITS_DEF'($urandom_range(1, 2048));
          end
          if ($urandom_range(3) == 0) begin
            g.height = COORD_BITS_DEF'($urandom_range(1, 2048));
          end else begin
            g.height = COORD_BITS_DEF'($urandom_range(1, 128));
          end
          g.chains = CHAIN_BITS'($urandom_range(0, 8));
          g.rotation = ROT_BITS'($urandom_range(3));
        end
      endcase
      apply_geometry(g);
      repeat (PIXELS_PER_PHASE) send_pixel(random_pixel());
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    remap_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{panel_x_o, panel_y_o, red_out_o, green_out_o, blue_out_o, visible_o};
      if (pending_remaps.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("result with no pixel pending: x=%0d y=%0d rgb=%h/%h/%h vis=%b",
                   got.panel_x, got.panel_y, got.red, got.green, got.blue, got.visible);
        end
        mismatch_count++;
      end else begin
        want = pending_remaps.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected x=%0d y=%0d rgb=%h/%h/%h vis=%b",
                     want.panel_x, want.panel_y, want.red, want.green, want.blue, want.visible);
            $display("          actual   x=%0d y=%0d rgb=%h/%h/%h vis=%b",
                     got.panel_x, got.panel_y, got.red, got.green, got.blue, got.visible);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("led_panel_coordinate_remapper_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_rotations();
    test_fold();
    test_fold_corner_cases();
    test_random_traffic();
    drain_stream();
    if (mismatch_count == 0 && pending_remaps.size() == 0) begin
      $display("led_panel_coordinate_remapper_unit verification clean");
    end else begin
      $display("led_panel_coordinate_remapper_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lpcr_pkg.sv
sv/lpcr_div.sv
sv/led_panel_coordinate_remapper_unit.sv
sv/lpcr_checker.sv
dv/led_panel_coordinate_remapper_unit_tb.sv
